// File: design/bivu_pkg.sv
package bivu_pkg;

    localparam int TS_W       = 64;
    localparam int PCT_W      = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int SCALE_SH   = 18;
    localparam int PROD_W     = TS_W + 5;
    localparam int DVD_W      = PROD_W + SCALE_SH;
    localparam int CNT_W      = $clog2(DVD_W);

    localparam logic [PCT_W-1:0]     PCT_FULL = PCT_W'(6553600);
    localparam logic [CNT_W-1:0]     DIV_LAST = CNT_W'(DVD_W - 1);
    localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op         op;
        logic [TS_W-1:0] a;
        logic [TS_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TS_W-1:0] res;
        logic            flag;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WE,
        S_ADD,
        S_CLO,
        S_CHI,
        S_CLMS,
        S_CLME,
        S_MRG,
        S_EXT,
        S_LEN,
        S_ACC,
        S_SPAN,
        S_FLEN,
        S_FACC,
        S_CMP,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// File: design/bivu_evt_if.sv
interface bivu_evt_if;
    import bivu_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [TS_W-1:0]        ev_start;
    logic signed [TS_W-1:0] event_duration;

    modport source (output valid, mode, ev_start, event_duration, input ready);
    modport sink   (input valid, mode, ev_start, event_duration, output ready);
endinterface

// File: design/bivu_res_if.sv
interface bivu_res_if;
    import bivu_pkg::*;

    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  busy_time;
    logic [PCT_W-1:0] utilization_pct;

    modport source (output valid, busy_time, utilization_pct, input ready);
    modport sink   (input valid, busy_time, utilization_pct, output ready);
endinterface

// File: design/busy_interval_utilization_top.sv
// Event request: dropped in the idle state if the duration is not positive,
// else checked against the window, clipped and merged; one shared 64-bit add/sub unit.
// Finish request: the ratio may need the bit-serial division (one restoring
// step per cycle on the same unit).
// One request at a time; a finished result waits in the output register.
// Synchronous active-low reset clears the window registers and the busy state.
module busy_interval_utilization_top
    import bivu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bivu_evt_if.sink             i_evt,
    bivu_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TS_W-1:0]      i_cfg_data
);

    logic [TS_W-1:0] r_win_start;
    logic [TS_W-1:0] r_win_end;
    t_alu_req        w_alu_req;
    t_alu_rsp        w_alu_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIN_START: r_win_start <= i_cfg_data;
                REG_WIN_END:   r_win_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bivu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_start (r_win_start),
        .i_win_end   (r_win_end),
        .i_evt       (i_evt),
        .o_res       (o_res),
        .o_alu_req   (w_alu_req),
        .i_alu_rsp   (w_alu_rsp)
    );

    bivu_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

endmodule

// File: design/bivu_alu.sv
module bivu_alu
    import bivu_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [TS_W:0] w_sum;

    // flag: carry out on add, borrow (a < b) on subtract
    always_comb begin
        unique case (i_req.op)
            ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: w_sum = '0;
        endcase
        o_rsp.res  = w_sum[TS_W-1:0];
        o_rsp.flag = w_sum[TS_W];
    end

endmodule

// File: design/bivu_seq.sv
module bivu_seq
    import bivu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TS_W-1:0]   i_win_start,
    input  logic [TS_W-1:0]   i_win_end,
    bivu_evt_if.sink          i_evt,
    bivu_res_if.source        o_res,
    output t_alu_req          o_alu_req,
    input  t_alu_rsp          i_alu_rsp
);

    t_state            r_state, n_state;
    logic              r_mode, n_mode;
    logic [TS_W-1:0]   r_s, n_s;
    logic [TS_W-1:0]   r_e, n_e;
    logic [TS_W-1:0]   r_d, n_d;
    logic [TS_W-1:0]   r_we, n_we;
    logic [TS_W-1:0]   r_span, n_span;
    logic [TS_W-1:0]   r_busy, n_busy;
    logic [TS_W-1:0]   r_tmp, n_tmp;
    logic [TS_W-1:0]   r_open_start, n_open_start;
    logic [TS_W-1:0]   r_open_end, n_open_end;
    logic [TS_W-1:0]   r_sum, n_sum;
    logic              r_have, n_have;
    logic [TS_W-1:0]   r_rem, n_rem;
    logic [PCT_W-1:0]  r_quo, n_quo;
    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PCT_W-1:0]  r_pct, n_pct;
    logic              r_out_valid, n_out_valid;
    logic [TS_W-1:0]   r_out_busy, n_out_busy;
    logic [PCT_W-1:0]  r_out_pct, n_out_pct;

    logic [TS_W-1:0]   w_res;
    logic              w_flag;
    logic [TS_W-1:0]   w_sat;
    logic [TS_W-1:0]   w_div_a;
    logic              w_take;
    logic [PROD_W-1:0] w_prod;

    assign w_res   = i_alu_rsp.res;
    assign w_flag  = i_alu_rsp.flag;
    assign w_sat   = w_flag ? '1 : w_res;
    assign w_div_a = {r_rem[TS_W-2:0], r_dvd[DVD_W-1]};
    assign w_take  = r_rem[TS_W-1] | ~w_flag;
    // busy * 25, the rest of the scale is a shift
    assign w_prod  = (PROD_W'(r_busy) << 4) + (PROD_W'(r_busy) << 3) + PROD_W'(r_busy);

    assign i_evt.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.busy_time       = r_out_busy;
    assign o_res.utilization_pct = r_out_pct;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_s          = r_s;
        n_e          = r_e;
        n_d          = r_d;
        n_we         = r_we;
        n_span       = r_span;
        n_busy       = r_busy;
        n_tmp        = r_tmp;
        n_open_start = r_open_start;
        n_open_end   = r_open_end;
        n_sum        = r_sum;
        n_have       = r_have;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_dvd        = r_dvd;
        n_cnt        = r_cnt;
        n_pct        = r_pct;
        n_out_valid  = r_out_valid & ~o_res.ready;
        n_out_busy   = r_out_busy;
        n_out_pct    = r_out_pct;
        o_alu_req.op = ALU_SUB;
        o_alu_req.a  = r_s;
        o_alu_req.b  = r_e;

        unique case (r_state)
            S_IDLE: begin
                if (i_evt.valid) begin
                    n_mode = i_evt.mode;
                    n_s    = i_evt.ev_start;
                    n_d    = $unsigned(i_evt.event_duration);
                    if (i_evt.mode ||
                        (!i_evt.event_duration[TS_W-1] && i_evt.event_duration != '0)) begin
                        n_state = S_WE;
                    end
                end
            end
            S_WE: begin
                o_alu_req.a = i_win_end;
                o_alu_req.b = i_win_start;
                n_we    = w_flag ? i_win_start : i_win_end;
                n_state = r_mode ? S_SPAN : S_ADD;
            end
            S_ADD: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = r_s;
                o_alu_req.b  = r_d;
                n_e     = w_sat;
                n_state = S_CLO;
            end
            S_CLO: begin
                o_alu_req.a = i_win_start;
                o_alu_req.b = r_e;
                n_state = w_flag ? S_CHI : S_IDLE;
            end
            S_CHI: begin
                o_alu_req.a = r_s;
                o_alu_req.b = r_we;
                n_state = w_flag ? S_CLMS : S_IDLE;
            end
            S_CLMS: begin
                o_alu_req.a = r_s;
                o_alu_req.b = i_win_start;
                if (w_flag) begin
                    n_s = i_win_start;
                end
                n_state = S_CLME;
            end
            S_CLME: begin
                o_alu_req.a = r_we;
                o_alu_req.b = r_e;
                n_e = w_flag ? r_we : r_e;
                if (!r_have) begin
                    n_open_start = r_s;
                    n_open_end   = w_flag ? r_we : r_e;
                    n_have       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_MRG;
                end
            end
            S_MRG: begin
                o_alu_req.a = r_open_end;
                o_alu_req.b = r_s;
                n_state = w_flag ? S_LEN : S_EXT;
            end
            S_EXT: begin
                o_alu_req.a = r_open_end;
                o_alu_req.b = r_e;
                if (w_flag) begin
                    n_open_end = r_e;
                end
                n_state = S_IDLE;
            end
            S_LEN: begin
                o_alu_req.a = r_open_end;
                o_alu_req.b = r_open_start;
                n_tmp   = w_res;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = r_sum;
                o_alu_req.b  = r_tmp;
                n_sum        = w_sat;
                n_open_start = r_s;
                n_open_end   = r_e;
                n_state      = S_IDLE;
            end
            S_SPAN: begin
                o_alu_req.a = r_we;
                o_alu_req.b = i_win_start;
                n_span  = w_res;
                n_busy  = r_sum;
                n_state = r_have ? S_FLEN : S_CMP;
            end
            S_FLEN: begin
                o_alu_req.a = r_open_end;
                o_alu_req.b = r_open_start;
                n_tmp   = w_res;
                n_state = w_flag ? S_CMP : S_FACC;
            end
            S_FACC: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = r_busy;
                o_alu_req.b  = r_tmp;
                n_busy  = w_sat;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_alu_req.a = r_busy;
                o_alu_req.b = r_span;
                if (r_busy == '0) begin
                    n_pct   = '0;
                    n_state = S_DONE;
                end else if (!w_flag) begin
                    n_pct   = PCT_FULL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_dvd   = {w_prod, {SCALE_SH{1'b0}}};
                n_rem   = '0;
                n_quo   = '0;
                n_cnt   = DIV_LAST;
                n_state = S_DIV;
            end
            S_DIV: begin
                // one restoring step per cycle, dividend MSB first
                o_alu_req.a = w_div_a;
                o_alu_req.b = r_span;
                n_rem = w_take ? w_res : w_div_a;
                n_quo = {r_quo[PCT_W-2:0], w_take};
                n_dvd = r_dvd << 1;
                if (r_cnt == '0) begin
                    n_pct   = {r_quo[PCT_W-2:0], w_take};
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_busy   = r_busy;
                    n_out_pct    = r_pct;
                    n_open_start = '0;
                    n_open_end   = '0;
                    n_sum        = '0;
                    n_have       = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_start <= '0;
            r_open_end   <= '0;
            r_sum        <= '0;
            r_have       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_open_start <= n_open_start;
            r_open_end   <= n_open_end;
            r_sum        <= n_sum;
            r_have       <= n_have;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_s        <= n_s;
        r_e        <= n_e;
        r_d        <= n_d;
        r_we       <= n_we;
        r_span     <= n_span;
        r_busy     <= n_busy;
        r_tmp      <= n_tmp;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dvd      <= n_dvd;
        r_cnt      <= n_cnt;
        r_pct      <= n_pct;
        r_out_busy <= n_out_busy;
        r_out_pct  <= n_out_pct;
    end

endmodule

// File: sim/busy_interval_utilization_chk.sv
module busy_interval_utilization_chk
    import bivu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bivu_evt_if                  i_evt,
    bivu_res_if                  i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TS_W-1:0]      i_cfg_data,
    output int                   o_err_cnt,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TS_W-1:0]  busy;
        logic [PCT_W-1:0] pct;
    } t_usage;

    logic [TS_W-1:0] win_lo;
    logic [TS_W-1:0] win_hi;
    logic [TS_W-1:0] run_start;
    logic [TS_W-1:0] run_end;
    logic [TS_W-1:0] closed_total;
    logic            run_open;

    t_usage expected_usage[$];
    int     err_total = 0;
    int     pending_n = 0;

    assign o_err_cnt = err_total;
    assign o_pending = pending_n;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_total++;
    endtask

    function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
                                                input logic [TS_W-1:0] b);
        logic [TS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TS_W] ? '1 : s[TS_W-1:0];
    endfunction

    task automatic clear_runs();
        run_start    = '0;
        run_end      = '0;
        closed_total = '0;
        run_open     = 1'b0;
    endtask

    // merge one event into the running union, or close the window on finish
    task automatic track_request(input logic mode, input logic [TS_W-1:0] st,
                                 input logic [TS_W-1:0] du);
        logic [TS_W-1:0] lo;
        logic [TS_W-1:0] hi;
        logic [TS_W-1:0] s;
        logic [TS_W-1:0] e;
        logic [TS_W-1:0] span;
        logic [TS_W-1:0] busy;
        logic [127:0]    prod;
        t_usage          u;
        lo = win_lo;
        hi = (win_hi < win_lo) ? win_lo : win_hi;
        if (!mode) begin
            if (du[TS_W-1] || du == '0)
                return;
            e = sat_add(st, du);
            if (e <= lo || st >= hi)
                return;
            s = (st < lo) ? lo : st;
            if (e > hi)
                e = hi;
            if (!run_open) begin
                run_start = s;
                run_end   = e;
                run_open  = 1'b1;
            end else if (s <= run_end) begin
                if (e > run_end)
                    run_end = e;
            end else begin
                closed_total = sat_add(closed_total, run_end - run_start);
                run_start    = s;
                run_end      = e;
            end
        end else begin
            busy = closed_total;
            span = hi - lo;
            if (run_open && run_end >= run_start)
                busy = sat_add(busy, run_end - run_start);
            u.busy = busy;
            if (busy == '0) begin
                u.pct = '0;
            end else if (span == '0 || busy >= span) begin
                u.pct = PCT_FULL;
            end else begin
                prod  = {64'd0, busy} * 128'(PCT_FULL);
                u.pct = PCT_W'(prod / {64'd0, span});
            end
            expected_usage.insert(expected_usage.size(), u);
            clear_runs();
        end
    endtask

    always @(posedge i_clk) begin
        t_usage want;
        if (!i_rst_n) begin
            win_lo = '0;
            win_hi = '0;
            clear_runs();
            expected_usage.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIN_START: win_lo = i_cfg_data;
                    REG_WIN_END:   win_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_usage.size() == 0) begin
                    report_mismatch($sformatf("unexpected result busy=%0h pct=%0h",
                                              i_res.busy_time, i_res.utilization_pct));
                end else begin
                    want = expected_usage.pop_front();
                    if (i_res.busy_time !== want.busy)
                        report_mismatch($sformatf("busy_time expected %0h got %0h",
                                                  want.busy, i_res.busy_time));
                    if (i_res.utilization_pct !== want.pct)
                        report_mismatch($sformatf("utilization_pct expected %0h got %0h",
                                                  want.pct, i_res.utilization_pct));
                end
            end
            if (i_evt.valid && i_evt.ready)
                track_request(i_evt.mode, i_evt.ev_start, i_evt.event_duration);
        end
        pending_n <= expected_usage.size();
    end

endmodule

// File: sim/busy_interval_utilization_top_tb.sv
module busy_interval_utilization_top_tb;
    import bivu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEM_TARGET = 1200;
    localparam int          STEADY_FROM = 1030;
    localparam int          HOLD_CYCLES = 300;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          SETTLE      = 16;
    localparam logic [63:0] DUR_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DUR_MIN     = 64'h8000_0000_0000_0000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TS_W-1:0]      i_cfg_data;
    int                   err_cnt;
    int                   pending;
    int                   quiet = 0;
    int                   items_sent;
    bit                   steady;
    bit                   hold_go;

    bivu_evt_if evt ();
    bivu_res_if res ();

    busy_interval_utilization_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    busy_interval_utilization_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .i_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rnd_below(input logic [63:0] n);
        if (n == '0)
            return '0;
        return rand64() % n;
    endfunction

    task automatic send_req(input logic mode, input logic [63:0] st, input logic [63:0] du);
        if (!steady && $urandom_range(0, 4) == 0) begin
            evt.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        evt.valid          <= 1'b1;
        evt.mode           <= mode;
        evt.ev_start       <= st;
        evt.event_duration <= du;
        @(posedge i_clk);
        while (!evt.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic finish_window();
        send_req(1'b1, rand64(), rand64());
    endtask

    task automatic drain();
        evt.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [63:0] lo, input logic [63:0] hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WIN_START;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= REG_WIN_END;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly time-sorted events with some noise, usually closed by a finish
    task automatic run_sequence(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] span;
        logic [63:0] step;
        logic [63:0] t;
        logic [63:0] du;
        int          len;
        span = (hi > lo) ? hi - lo : 64'd100;
        len  = $urandom_range(1, 20);
        step = span / 64'(len) + 64'd1;
        t    = lo - rnd_below(step);
        if (t > lo)
            t = '0;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 19))
                0: send_req(1'b0, rand64(), rand64());
                1: send_req(1'b0, t, 64'd0 - rnd_below(DUR_MIN + 64'd1));
                2: send_req(1'b0, rnd_below(t + 64'd1), 64'd1 + rnd_below(step));
                default: begin
                    t  = t + rnd_below(step / 2 + 64'd1);
                    du = 64'd1 + rnd_below(step);
                    if (du[63])
                        du = DUR_MAX;
                    send_req(1'b0, t, du);
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            finish_window();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (evt.valid && evt.ready) || (res.valid && res.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : sink_side
        bit held;
        held = 1'b0;
        res.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_go && !held) begin
                held = 1'b1;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                res.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin : source_side
        logic [63:0] lo;
        logic [63:0] hi;
        int          phase;
        items_sent = 0;
        steady     = 1'b0;
        hold_go    = 1'b0;
        phase      = 0;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= REG_WIN_START;
        i_cfg_data         <= '0;
        evt.valid          <= 1'b0;
        evt.mode           <= 1'b0;
        evt.ev_start       <= '0;
        evt.event_duration <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // reset window is empty: everything dropped
        send_req(1'b0, 64'd100, 64'd50);
        finish_window();
        drain();

        set_window(64'd1000, 64'd2000);
        send_req(1'b0, 64'd0, 64'd0);
        send_req(1'b0, 64'd5, DUR_MIN);
        send_req(1'b0, 64'd500, 64'd600);
        send_req(1'b0, 64'd1050, 64'd100);
        send_req(1'b0, 64'd1100, 64'd20);
        send_req(1'b0, 64'd1300, 64'd100);
        send_req(1'b0, 64'd1200, 64'd300);
        send_req(1'b0, 64'd2000, 64'd10);
        send_req(1'b0, 64'd0, 64'd1000);
        send_req(1'b0, 64'd1900, DUR_MAX);
        finish_window();
        finish_window();
        send_req(1'b0, 64'd0, DUR_MAX);
        finish_window();
        drain();

        // full range, end saturation and large ratios
        set_window(64'd0, '1);
        send_req(1'b0, 64'hFFFF_FFFF_FFFF_FFF0, DUR_MAX);
        send_req(1'b0, '1, 64'd1);
        send_req(1'b0, 64'd0, DUR_MAX);
        finish_window();
        send_req(1'b0, 64'd3, DUR_MAX);
        send_req(1'b0, 64'h8000_0000_0000_0005, DUR_MAX);
        finish_window();
        drain();

        // end below start
        set_window(64'd5000, 64'd100);
        send_req(1'b0, 64'd100, 64'd10000);
        finish_window();
        drain();

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 6))
                0: begin
                    lo = rnd_below(64'd100000);
                    hi = lo + 64'd1 + rnd_below(64'd5000);
                end
                1: begin
                    lo = rand64();
                    hi = lo + 64'd1 + rnd_below(64'd1 << 20);
                    if (hi < lo)
                        hi = '1;
                end
                2: begin
                    lo = '0;
                    hi = '1;
                end
                3: begin
                    lo = rand64();
                    hi = rand64();
                end
                4: begin
                    lo = rand64();
                    hi = lo - rnd_below(64'd1000);
                end
                5: begin
                    lo = rnd_below(64'd1 << 40);
                    hi = lo + (rand64() >> 2);
                end
                default: begin
                    lo = $urandom_range(0, 1) ? '1 : '0;
                    hi = lo;
                end
            endcase
            set_window(lo, hi);
            phase++;
            if (phase == 2)
                hold_go = 1'b1;
            if (items_sent >= STEADY_FROM)
                steady = 1'b1;
            repeat ($urandom_range(2, 6)) run_sequence(lo, hi);
            finish_window();
            drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
